FILE: src/point_rotate_zoom_project_assert.svh
// ----------------------------------------------------------------------------
// Point rotate/zoom/project assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_ZOOM_PROJECT_ASSERT_SVH
`define POINT_ROTATE_ZOOM_PROJECT_ASSERT_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define PRZP_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define PRZP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/przp_pkg.sv
// ----------------------------------------------------------------------------
// Point rotate/zoom/project package
// Item types, image geometry, register indexes and rounding constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package przp_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	// Register stages from input to output register.
	localparam int NUM_STAGES = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_COS_Z          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN_Z          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_X          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN_X          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_GAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_STRETCH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_X          = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_Y          = 3'd7;

	// Half image size at 32 fraction bits.
	localparam logic signed [63:0] HALF_W = 64'(IMAGE_WIDTH) <<< 31;
	localparam logic signed [63:0] HALF_H = 64'(IMAGE_HEIGHT) <<< 31;

	// Round half away from zero: add half, less one for negative values, then floor.
	localparam logic signed [63:0] RND32     = 64'sd1 <<< 31;
	localparam logic signed [63:0] RND32_NEG = (64'sd1 <<< 31) - 64'sd1;
	localparam logic signed [62:0] RND28     = 63'sd1 <<< 27;
	localparam logic signed [62:0] RND28_NEG = (63'sd1 <<< 27) - 63'sd1;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic signed [15:0] depth;
		logic               in_image;
		logic               last_out;
	} pixel_t;

endpackage

FILE: src/point_rotate_zoom_project.sv
// ----------------------------------------------------------------------------
// Point rotate, zoom and project
// Rotates model points about z then x, zooms, projects onto the image plane.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the pt channel (valid/ready), one item per point, and each
// produces exactly one item on the px channel: saturated pixel column and row,
// saturated depth, an in-image flag and a copy of the last-point mark.
// The eight rotation, zoom and pan registers are written through cfg_we,
// cfg_index and cfg_data; the user must see that they are only changed while no
// item is in flight, which the block does not enforce. Seven arithmetic stages
// and the output register lie between acceptance and px_valid. Throughput is
// one item per cycle while px_ready is high.
// Every stage has its own valid bit and loads whenever it is empty or the stage
// after it moves on, so when the receiver stalls the pipeline keeps taking
// points until all eight stages are full, and only then drops pt_ready.
// Reset clears all valid bits and restores the identity rotation, unit zoom,
// unit height stretch and zero pan; no clearing pass is needed afterward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "point_rotate_zoom_project_assert.svh"

module point_rotate_zoom_project (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pt_valid,
	output logic                             pt_ready,
	input  przp_pkg::point_t                 pt_data,
	output logic                             px_valid,
	input  logic                             px_ready,
	output przp_pkg::pixel_t                 px_data,
	input  logic                             cfg_we,
	input  logic [przp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [przp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import przp_pkg::*;

	// Configuration registers.
	logic signed [15:0] cos_z_q, sin_z_q, cos_x_q, sin_x_q;
	logic        [15:0] zoom_gain_q;
	logic signed [15:0] height_stretch_q, pan_x_q, pan_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_z_q          <= 16'sd16384;
			sin_z_q          <= '0;
			cos_x_q          <= 16'sd16384;
			sin_x_q          <= '0;
			zoom_gain_q      <= 16'd256;
			height_stretch_q <= 16'sd256;
			pan_x_q          <= '0;
			pan_y_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COS_Z:          cos_z_q          <= $signed(cfg_data);
				CFG_SIN_Z:          sin_z_q          <= $signed(cfg_data);
				CFG_COS_X:          cos_x_q          <= $signed(cfg_data);
				CFG_SIN_X:          sin_x_q          <= $signed(cfg_data);
				CFG_ZOOM_GAIN:      zoom_gain_q      <= cfg_data;
				CFG_HEIGHT_STRETCH: height_stretch_q <= $signed(cfg_data);
				CFG_PAN_X:          pan_x_q          <= $signed(cfg_data);
				CFG_PAN_Y:          pan_y_q          <= $signed(cfg_data);
			endcase
		end
	end

	// Pipeline flow control. Bit k is stage k+1; the last bit is the output
	// register. A stage advances when it is empty or its successor advances.
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] adv;

	always_comb begin
		adv[7] = !vld_q[7] || px_ready;
		adv[6] = !vld_q[6] || adv[7];
		adv[5] = !vld_q[5] || adv[6];
		adv[4] = !vld_q[4] || adv[5];
		adv[3] = !vld_q[3] || adv[4];
		adv[2] = !vld_q[2] || adv[3];
		adv[1] = !vld_q[1] || adv[2];
		adv[0] = !vld_q[0] || adv[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~adv) | ({vld_q[NUM_STAGES-2:0], pt_valid} & adv);
		end
	end

	assign pt_ready = adv[0];
	assign px_valid = vld_q[NUM_STAGES-1];

	// Stage 1: the five first-level products (rotation about z, height stretch).
	logic signed [31:0] czx_s1, szy_s1, szx_s1, czy_s1, hz_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			czx_s1  <= cos_z_q * pt_data.point_x;
			szy_s1  <= sin_z_q * pt_data.point_y;
			szx_s1  <= sin_z_q * pt_data.point_x;
			czy_s1  <= cos_z_q * pt_data.point_y;
			hz_s1   <= height_stretch_q * pt_data.point_z;
			last_s1 <= pt_data.last_point;
		end
	end

	// Stage 2: rotated x (d0) and rotated y (rot), both at 18 fraction bits.
	logic signed [32:0] d0_s2, rot_s2;
	logic signed [31:0] hz_s2;
	logic               last_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d0_s2   <= 33'(czx_s1) - 33'(szy_s1);
			rot_s2  <= 33'(szx_s1) + 33'(czy_s1);
			hz_s2   <= hz_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: products for the rotation about x.
	logic signed [48:0] cxrot_s3, sxrot_s3;
	logic signed [47:0] sxhz_s3, cxhz_s3;
	logic signed [32:0] d0_s3;
	logic               last_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cxrot_s3 <= cos_x_q * rot_s2;
			sxrot_s3 <= sin_x_q * rot_s2;
			sxhz_s3  <= sin_x_q * hz_s2;
			cxhz_s3  <= cos_x_q * hz_s2;
			d0_s3    <= d0_s2;
			last_s3  <= last_s2;
		end
	end

	// Stage 4: inner sums at 32 fraction bits, floored to 24 fraction bits.
	logic signed [54:0] in1_sum, in2_sum;
	logic signed [38:0] a0_s4;
	logic signed [45:0] a1_s4, a2_s4;
	logic               last_s4;

	always_comb begin
		in1_sum = 55'(cxrot_s3) - (55'(sxhz_s3) <<< 6);
		in2_sum = 55'(sxrot_s3) + (55'(cxhz_s3) <<< 6);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			a0_s4   <= 39'(d0_s3) <<< 6;
			a1_s4   <= 46'(in1_sum >>> 8);
			a2_s4   <= 46'(in2_sum >>> 8);
			last_s4 <= last_s3;
		end
	end

	// Stage 5: zoom, back to 32 fraction bits.
	logic signed [16:0] zoom_s;
	logic signed [55:0] r0_s5;
	logic signed [62:0] r1_s5, r2_s5;
	logic               last_s5;

	assign zoom_s = $signed({1'b0, zoom_gain_q});

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			r0_s5   <= a0_s4 * zoom_s;
			r1_s5   <= a1_s4 * zoom_s;
			r2_s5   <= a2_s4 * zoom_s;
			last_s5 <= last_s4;
		end
	end

	// Stage 6: image center and pan offsets.
	logic signed [63:0] vcol_s6, vrow_s6;
	logic signed [62:0] r2_s6;
	logic               last_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			vcol_s6 <= 64'(r0_s5) + HALF_W + (64'(pan_x_q) <<< 32);
			vrow_s6 <= 64'(r1_s5) + HALF_H + (64'(pan_y_q) <<< 32);
			r2_s6   <= r2_s5;
			last_s6 <= last_s5;
		end
	end

	// Stage 7: rounding half away from zero to integer pixels and Q12.4 depth.
	logic signed [63:0] col_sum, row_sum;
	logic signed [62:0] dep_sum;
	logic signed [31:0] col_s7, row_s7;
	logic signed [34:0] dep_s7;
	logic               last_s7;

	always_comb begin
		col_sum = vcol_s6 + (vcol_s6[63] ? RND32_NEG : RND32);
		row_sum = vrow_s6 + (vrow_s6[63] ? RND32_NEG : RND32);
		dep_sum = r2_s6 + (r2_s6[62] ? RND28_NEG : RND28);
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			col_s7  <= 32'(col_sum >>> 32);
			row_s7  <= 32'(row_sum >>> 32);
			dep_s7  <= 35'(dep_sum >>> 28);
			last_s7 <= last_s6;
		end
	end

	// Output register: saturation and the image bounds test, which looks at
	// the rounded values before saturation.
	function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
		logic signed [15:0] r;
		if (v > 35'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -35'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	pixel_t out_s8;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			out_s8.pixel_x  <= sat16(35'(col_s7));
			out_s8.pixel_y  <= sat16(35'(row_s7));
			out_s8.depth    <= sat16(dep_s7);
			out_s8.in_image <= (col_s7 >= 0) && (col_s7 <= 32'(IMAGE_WIDTH - 1)) &&
			                   (row_s7 >= 0) && (row_s7 <= 32'(IMAGE_HEIGHT - 1));
			out_s8.last_out <= last_s7;
		end
	end

	assign px_data = out_s8;

	// Assertions.
	`PRZP_ASSERT_IMPL(a_stall_only_when_full, !pt_ready, &vld_q, "input stalled with a bubble in the pipeline")
	`PRZP_ASSERT_IMPL(a_drain_frees_input, px_ready, pt_ready, "input stalled while the output drains")
	`PRZP_ASSERT_NEXT(a_accept_fills_stage1, pt_valid && pt_ready, vld_q[0], "accepted item did not reach stage one")
	`PRZP_ASSERT_IMPL(a_in_image_bounds, px_valid && px_data.in_image, (px_data.pixel_x >= 0) && (px_data.pixel_x <= 16'(IMAGE_WIDTH - 1)) && (px_data.pixel_y >= 0) && (px_data.pixel_y <= 16'(IMAGE_HEIGHT - 1)), "in-image flag set for a pixel outside the image")

endmodule
